### hdl/aging_page_replacement_defines.svh
// Assertion macros used by the verification checker.
`ifndef AGING_PAGE_REPLACEMENT_DEFINES_SVH
`define AGING_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define APR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define APR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/apr_pkg.sv
`timescale 1ns / 1ps

package apr_pkg;

   // FRAMES must be a multiple of CELL_FRAMES, with at least two cells.
   localparam int FRAMES      = 64;
   localparam int PAGE_BITS   = 16;
   localparam int AGE_BITS    = 16;
   localparam int CELL_FRAMES = 8;
   localparam int CELLS       = FRAMES / CELL_FRAMES;

   localparam int IDX_W      = $clog2(FRAMES);
   localparam int FCNT_W     = $clog2(FRAMES + 1);
   localparam int CELL_IDX_W = $clog2(CELL_FRAMES);
   localparam int CELL_ID_W  = $clog2(CELLS);

   localparam int PAGE_W     = 16;
   localparam int FIU_W      = 7;
   localparam int ILEN_W     = 16;
   localparam int SLOT_W     = 6;
   localparam int FAULT_W    = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic [FIU_W-1:0]    FIU_RESET  = 7'd64;
   localparam logic [ILEN_W-1:0]   ILEN_RESET = 16'd1000;
   localparam logic [FAULT_W-1:0]  FAULT_MAX  = '1;
   localparam logic [AGE_BITS-1:0] AGE_TOP    = {1'b1, {(AGE_BITS-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAMES_IN_USE,
      CSR_INTERVAL_LENGTH
   } csr_idx_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // Running search result handed from cell to cell.
   typedef struct packed {
      logic                hit;
      logic [IDX_W-1:0]    hit_idx;
      logic                free_found;
      logic [IDX_W-1:0]    free_idx;
      logic                min_found;
      logic [AGE_BITS-1:0] min_age;
      logic [IDX_W-1:0]    min_idx;
   } scan_rec_type;

   localparam scan_rec_type REC_INIT = '0;

   typedef struct packed {
      logic shift;
      logic flush;
   } cell_ctl_type;

   typedef struct packed {
      logic                 we;
      logic                 hit;
      logic [IDX_W-1:0]     slot;
      logic [PAGE_BITS-1:0] tag;
   } commit_type;

   typedef struct packed {
      logic               iend;
      logic [FAULT_W-1:0] fault_count;
      logic [SLOT_W-1:0]  frame_slot;
      logic               hit;
   } rsp_type;

   function automatic logic [FCNT_W-1:0] active_frames(logic [FIU_W-1:0] v);
      if (v == '0) begin
         return FCNT_W'(1);
      end
      if (int'(v) > FRAMES) begin
         return FCNT_W'(FRAMES);
      end
      return FCNT_W'(v);
   endfunction

endpackage

### hdl/apr_cell.sv
`timescale 1ns / 1ps

module apr_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [apr_pkg::CELL_ID_W-1:0]      cell_id,
   input  apr_pkg::cell_ctl_type              ctl,
   input  apr_pkg::commit_type                commit,
   input  logic [apr_pkg::PAGE_BITS-1:0]      query_tag,
   input  logic [apr_pkg::FCNT_W-1:0]         active_n,
   input  logic                               up_tok,
   input  apr_pkg::scan_rec_type              up_rec,
   output logic                               dn_tok,
   output apr_pkg::scan_rec_type              dn_rec
);
   import apr_pkg::*;

   logic [PAGE_BITS-1:0] tag_ff   [CELL_FRAMES];
   logic [PAGE_BITS-1:0] tag_in   [CELL_FRAMES];
   logic                 valid_ff [CELL_FRAMES];
   logic                 valid_in [CELL_FRAMES];
   logic [AGE_BITS-1:0]  age_ff   [CELL_FRAMES];
   logic [AGE_BITS-1:0]  age_in   [CELL_FRAMES];
   logic [IDX_W-1:0]     frame_idx[CELL_FRAMES];
   logic                 tok_ff;
   scan_rec_type         rec_ff;
   scan_rec_type         rec_in;

   always_comb begin
      for (int j = 0; j < CELL_FRAMES; j++) begin
         frame_idx[j] = {cell_id, CELL_IDX_W'(j)};
      end
   end

   // Scan this cell's frames in index order; earlier cells already won ties.
   always_comb begin
      logic in_range;
      rec_in   = up_rec;
      in_range = 1'b0;
      for (int j = 0; j < CELL_FRAMES; j++) begin
         in_range = FCNT_W'(frame_idx[j]) < active_n;
         if (in_range) begin
            if (valid_ff[j] && tag_ff[j] == query_tag && !rec_in.hit) begin
               rec_in.hit     = 1'b1;
               rec_in.hit_idx = frame_idx[j];
            end
            if (!valid_ff[j] && !rec_in.free_found) begin
               rec_in.free_found = 1'b1;
               rec_in.free_idx   = frame_idx[j];
            end
            if (!rec_in.min_found || age_ff[j] < rec_in.min_age) begin
               rec_in.min_found = 1'b1;
               rec_in.min_age   = age_ff[j];
               rec_in.min_idx   = frame_idx[j];
            end
         end
      end
   end

   always_comb begin
      for (int j = 0; j < CELL_FRAMES; j++) begin
         tag_in[j]   = tag_ff[j];
         valid_in[j] = valid_ff[j];
         age_in[j]   = age_ff[j];
         if (ctl.flush) begin
            valid_in[j] = 1'b0;
            age_in[j]   = '0;
         end else if (ctl.shift) begin
            age_in[j] = age_ff[j] >> 1;
         end else if (commit.we && commit.slot == frame_idx[j]) begin
            if (commit.hit) begin
               age_in[j] = age_ff[j] | AGE_TOP;
            end else begin
               tag_in[j]   = commit.tag;
               valid_in[j] = 1'b1;
               age_in[j]   = AGE_TOP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < CELL_FRAMES; j++) begin
            valid_ff[j] <= 1'b0;
            age_ff[j]   <= '0;
         end
         tok_ff <= 1'b0;
      end else begin
         for (int j = 0; j < CELL_FRAMES; j++) begin
            valid_ff[j] <= valid_in[j];
            age_ff[j]   <= age_in[j];
         end
         tok_ff <= up_tok;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < CELL_FRAMES; j++) begin
         tag_ff[j] <= tag_in[j];
      end
      rec_ff <= rec_in;
   end

   assign dn_tok = tok_ff;
   assign dn_rec = rec_ff;

endmodule

### hdl/apr_ctrl.sv
`timescale 1ns / 1ps

module apr_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [apr_pkg::PAGE_W-1:0]         req_page,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output apr_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [apr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [apr_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output apr_pkg::cell_ctl_type              cell_ctl,
   output apr_pkg::commit_type                commit,
   output logic [apr_pkg::PAGE_BITS-1:0]      query_tag,
   output logic [apr_pkg::FCNT_W-1:0]         active_n,
   output logic                               head_tok,
   input  logic                               tail_tok,
   input  apr_pkg::scan_rec_type              tail_rec
);
   import apr_pkg::*;

   state_type            state_ff, state_in;
   logic [FIU_W-1:0]     fiu_ff, fiu_in;
   logic [ILEN_W-1:0]    ilen_ff, ilen_in;
   logic [FCNT_W-1:0]    free_ff, free_in;
   logic [FAULT_W-1:0]   faults_ff, faults_in;
   logic [ILEN_W-1:0]    pos_ff, pos_in;
   logic [PAGE_BITS-1:0] tag_ff, tag_in;
   logic                 start_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept;
   logic                 flush;
   logic                 use_free;
   logic [IDX_W-1:0]     slot;
   logic [FAULT_W-1:0]   faults_bump;
   logic [ILEN_W-1:0]    len_eff;
   logic [ILEN_W:0]      pos_next;
   logic                 closes;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (tail_tok) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output slot must be empty or draining before a new request starts.
   always_comb begin
      case (state_ff)
         ST_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;
   assign flush  = csr_we && csr_index == CSR_FRAMES_IN_USE;

   always_comb begin
      use_free    = (free_ff != '0) && tail_rec.free_found;
      slot        = tail_rec.hit ? tail_rec.hit_idx :
                    use_free     ? tail_rec.free_idx : tail_rec.min_idx;
      faults_bump = (!tail_rec.hit && faults_ff != FAULT_MAX) ?
                    faults_ff + 1'b1 : faults_ff;
      len_eff     = (ilen_ff == '0) ? ILEN_W'(1) : ilen_ff;
      pos_next    = {1'b0, pos_ff} + 1'b1;
      closes      = pos_next >= {1'b0, len_eff};
   end

   always_comb begin
      fiu_in       = fiu_ff;
      ilen_in      = ilen_ff;
      free_in      = free_ff;
      faults_in    = faults_ff;
      pos_in       = pos_ff;
      tag_in       = accept ? req_page[PAGE_BITS-1:0] : tag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;

      if (flush) begin
         fiu_in  = csr_wdata[FIU_W-1:0];
         free_in = active_frames(csr_wdata[FIU_W-1:0]);
      end
      if (csr_we && csr_index == CSR_INTERVAL_LENGTH) begin
         ilen_in = csr_wdata[ILEN_W-1:0];
      end

      if (tail_tok) begin
         if (!tail_rec.hit && free_ff != '0) free_in = free_ff - 1'b1;
         faults_in              = closes ? '0 : faults_bump;
         pos_in                 = closes ? '0 : pos_next[ILEN_W-1:0];
         rsp_valid_in           = 1'b1;
         rsp_in.hit             = tail_rec.hit;
         rsp_in.frame_slot      = SLOT_W'(slot);
         rsp_in.fault_count     = faults_bump;
         rsp_in.iend            = closes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fiu_ff       <= FIU_RESET;
         ilen_ff      <= ILEN_RESET;
         free_ff      <= active_frames(FIU_RESET);
         faults_ff    <= '0;
         pos_ff       <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fiu_ff       <= fiu_in;
         ilen_ff      <= ilen_in;
         free_ff      <= free_in;
         faults_ff    <= faults_in;
         pos_ff       <= pos_in;
         start_ff     <= accept;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      rsp_ff <= rsp_in;
   end

   // Ages shift at the accept edge so the scan sees post-shift values.
   assign cell_ctl.shift = accept;
   assign cell_ctl.flush = flush;
   assign commit.we      = tail_tok;
   assign commit.hit     = tail_rec.hit;
   assign commit.slot    = slot;
   assign commit.tag     = tag_ff;
   assign query_tag      = tag_ff;
   assign active_n       = active_frames(fiu_ff);
   assign head_tok       = start_ff;
   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_data       = rsp_ff;

endmodule

### hdl/aging_page_replacement.sv
`timescale 1ns / 1ps
// Aging page replacement engine. Each request carries a page number; the
// block looks it up among the active frames, ages every frame's counter,
// and on a miss fills the lowest free frame or evicts the frame with the
// smallest age (lowest index on ties). One request is handled at a time:
// frame state lives in a chain of CELLS cells (CELL_FRAMES frames each) and
// the search record walks that chain one cell per clock, through each
// cell's register, and the controller then commits the frame update and
// registers the result. The next request can be taken in the cycle that
// result appears, if it is taken at once. A finished result sits in an
// output register until taken, and no request is accepted while it
// waits. Writing frames_in_use flushes all frames; both configuration
// registers may only be written while no request is in flight.

module aging_page_replacement (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [apr_pkg::PAGE_W-1:0]         req_tdata,   // [15:0] page
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] hit, [6:1] frame_slot, [22:7] fault_count, [23] zero
   output logic [apr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast,   // interval_end
   input  logic                               csr_we,
   input  logic [apr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [apr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import apr_pkg::*;

   cell_ctl_type         cell_ctl;
   commit_type           commit;
   logic [PAGE_BITS-1:0] query_tag;
   logic [FCNT_W-1:0]    active_n;
   logic                 tok [CELLS+1];
   scan_rec_type         rec [CELLS+1];
   rsp_type              rsp_data;

   apr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_page   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cell_ctl   (cell_ctl),
      .commit     (commit),
      .query_tag  (query_tag),
      .active_n   (active_n),
      .head_tok   (tok[0]),
      .tail_tok   (tok[CELLS]),
      .tail_rec   (rec[CELLS])
   );

   assign rec[0] = REC_INIT;

   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      apr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (CELL_ID_W'(k)),
         .ctl       (cell_ctl),
         .commit    (commit),
         .query_tag (query_tag),
         .active_n  (active_n),
         .up_tok    (tok[k]),
         .up_rec    (rec[k]),
         .dn_tok    (tok[k+1]),
         .dn_rec    (rec[k+1])
      );
   end

   assign rsp_tdata = {1'b0, rsp_data.fault_count, rsp_data.frame_slot, rsp_data.hit};
   assign rsp_tlast = rsp_data.iend;

endmodule

### hdl/apr_checker.sv
`timescale 1ns / 1ps
`include "aging_page_replacement_defines.svh"

module apr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [apr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                               rsp_tlast
);

   `APR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled response changed")

   // Only one request in flight at a time.
   `APR_ASSERT_NXT(a_one_req, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted during a scan")

   // The output slot is empty or draining when a request starts, and a result only follows a full scan.
   `APR_ASSERT_NXT(a_no_early_rsp, clock, reset, req_tvalid && req_tready, !rsp_tvalid, "response too early after request")

   `APR_ASSERT_NXT(a_rsp_gap, clock, reset, rsp_tvalid && rsp_tready, !rsp_tvalid, "back-to-back responses")

endmodule

bind aging_page_replacement apr_checker u_apr_checker (.*);

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import apr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 7;
   localparam int PHASE_REQS  = 250;

   typedef struct packed {
      logic               hit;
      logic [SLOT_W-1:0]  slot;
      logic [FAULT_W-1:0] faults;
      logic               iend;
   } lookup_result_t;

   typedef struct {
      bit             is_csr;
      csr_idx_type    idx;
      logic [15:0]    value;   // page for a request row, write data for a csr row
      bit             typed;
      lookup_result_t want;
   } script_row_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PAGE_W-1:0]     req_tdata;      // [15:0] page
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;      // [0] hit, [6:1] frame_slot, [22:7] fault_count
   logic                  rsp_tlast;      // interval_end
   logic                  csr_we;
   csr_idx_type           csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   aging_page_replacement dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the frame table
   logic [PAGE_W-1:0]   shadow_tags  [FRAMES];
   bit                  shadow_valid [FRAMES];
   logic [AGE_BITS-1:0] shadow_ages  [FRAMES];
   int                  free_left;
   logic [FAULT_W-1:0]  faults_now;
   logic [ILEN_W-1:0]   position_now;
   logic [FIU_W-1:0]    frames_reg;
   logic [ILEN_W-1:0]   ilen_reg;

   lookup_result_t pending_lookups[$];
   int             errors = 0;
   int             send_idle;
   int             recv_idle;
   int             results_seen = 0;
   int             hold_left = 0;
   bit             hold_done = 0;
   int             cycles = 0;

   function automatic int frames_live();
      if (frames_reg == '0) return 1;
      if (int'(frames_reg) > FRAMES) return FRAMES;
      return int'(frames_reg);
   endfunction

   function automatic void flush_table();
      for (int i = 0; i < FRAMES; i++) begin
         shadow_tags[i]  = '0;
         shadow_valid[i] = 0;
         shadow_ages[i]  = '0;
      end
      free_left = frames_live();
   endfunction

   function automatic void apply_register(csr_idx_type idx, logic [15:0] val);
      if (idx == CSR_FRAMES_IN_USE) begin
         frames_reg = val[FIU_W-1:0];
         flush_table();
      end else begin
         ilen_reg = val;
      end
   endfunction

   function automatic lookup_result_t age_and_lookup(logic [PAGE_W-1:0] page);
      lookup_result_t      r;
      int                  n;
      int                  slot;
      bit                  hit;
      bit                  found;
      logic [AGE_BITS-1:0] best;
      int unsigned         len;
      int unsigned         next_pos;
      n = frames_live();
      slot = 0;
      hit = 0;
      found = 0;
      for (int i = 0; i < FRAMES; i++) shadow_ages[i] = shadow_ages[i] >> 1;
      for (int i = 0; i < n; i++) begin
         if (shadow_valid[i] && shadow_tags[i] == page) begin
            hit = 1;
            slot = i;
            break;
         end
      end
      if (hit) begin
         shadow_ages[slot] = shadow_ages[slot] | AGE_TOP;
      end else begin
         if (faults_now != FAULT_MAX) faults_now = faults_now + 1'b1;
         if (free_left != 0) begin
            for (int i = 0; i < n; i++) begin
               if (!shadow_valid[i]) begin
                  slot = i;
                  found = 1;
                  break;
               end
            end
            free_left--;
         end
         // evict the oldest frame, lowest index wins ties
         if (!found) begin
            best = shadow_ages[0];
            slot = 0;
            for (int i = 1; i < n; i++) begin
               if (shadow_ages[i] < best) begin
                  best = shadow_ages[i];
                  slot = i;
               end
            end
         end
         shadow_tags[slot]  = page;
         shadow_valid[slot] = 1;
         shadow_ages[slot]  = AGE_TOP;
      end
      r.hit    = hit;
      r.slot   = slot[SLOT_W-1:0];
      r.faults = faults_now;
      len = (ilen_reg == '0) ? 1 : int'(ilen_reg);
      next_pos = int'(position_now) + 1;
      r.iend = (next_pos >= len);
      if (r.iend) begin
         position_now = '0;
         faults_now   = '0;
      end else begin
         position_now = next_pos[ILEN_W-1:0];
      end
      return r;
   endfunction

   task automatic send_page(input logic [PAGE_W-1:0] page, input bit typed,
                            input lookup_result_t want);
      lookup_result_t predicted;
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= page;
      do @(posedge clock); while (!req_tready);
      predicted = age_and_lookup(page);
      pending_lookups.push_back(typed ? want : predicted);
   endtask

   task automatic drain_lookups();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_lookups.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [15:0] val);
      drain_lookups();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      apply_register(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // result checker and receiver back-pressure
   always @(posedge clock) begin
      lookup_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_lookups.size() == 0) begin
            $error("unexpected result: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_tdata[0] !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[6:1] !== want.slot) begin
               $error("frame_slot: expected %0d, got %0d", want.slot, rsp_tdata[6:1]);
               errors++;
            end
            if (rsp_tdata[22:7] !== want.faults) begin
               $error("fault_count: expected %0d, got %0d", want.faults, rsp_tdata[22:7]);
               errors++;
            end
            if (rsp_tlast !== want.iend) begin
               $error("interval_end: expected %0d, got %0d", want.iend, rsp_tlast);
               errors++;
            end
            if (rsp_tdata[23] !== 1'b0) begin
               $error("pad: expected 0, got %0d", rsp_tdata[23]);
               errors++;
            end
         end
      end
      // long hold-off once, while the sender keeps streaming
      if (!hold_done && results_seen == 1400) begin
         hold_done = 1;
         hold_left = 400;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   script_row_t script[$] = '{
      '{0, CSR_FRAMES_IN_USE,   16'h0000, 1, '{1'b0, 6'd0, 16'd1, 1'b0}},
      '{0, CSR_FRAMES_IN_USE,   16'hFFFF, 1, '{1'b0, 6'd1, 16'd2, 1'b0}},
      '{0, CSR_FRAMES_IN_USE,   16'h0000, 1, '{1'b1, 6'd0, 16'd2, 1'b0}},
      '{0, CSR_FRAMES_IN_USE,   16'hFFFF, 1, '{1'b1, 6'd1, 16'd2, 1'b0}},
      // zero frames acts as one frame
      '{1, CSR_FRAMES_IN_USE,   16'h0000, 0, '0},
      '{0, CSR_FRAMES_IN_USE,   16'h1234, 1, '{1'b0, 6'd0, 16'd3, 1'b0}},
      '{0, CSR_FRAMES_IN_USE,   16'h1234, 1, '{1'b1, 6'd0, 16'd3, 1'b0}},
      '{0, CSR_FRAMES_IN_USE,   16'h4321, 1, '{1'b0, 6'd0, 16'd4, 1'b0}},
      // interval shortened below the current position
      '{1, CSR_INTERVAL_LENGTH, 16'd2,    0, '0},
      '{0, CSR_FRAMES_IN_USE,   16'h4321, 1, '{1'b1, 6'd0, 16'd4, 1'b1}},
      '{0, CSR_FRAMES_IN_USE,   16'h0001, 1, '{1'b0, 6'd0, 16'd1, 1'b0}},
      '{0, CSR_FRAMES_IN_USE,   16'h0001, 1, '{1'b1, 6'd0, 16'd1, 1'b1}},
      // zero length closes every interval
      '{1, CSR_INTERVAL_LENGTH, 16'd0,    0, '0},
      '{0, CSR_FRAMES_IN_USE,   16'hAAAA, 1, '{1'b0, 6'd0, 16'd1, 1'b1}},
      '{0, CSR_FRAMES_IN_USE,   16'hAAAA, 1, '{1'b1, 6'd0, 16'd0, 1'b1}},
      '{1, CSR_INTERVAL_LENGTH, 16'hFFFF, 0, '0},
      // 127 clamps to the full table
      '{1, CSR_FRAMES_IN_USE,   16'hFFFF, 0, '0},
      '{0, CSR_FRAMES_IN_USE,   16'h5555, 1, '{1'b0, 6'd0, 16'd1, 1'b0}},
      '{0, CSR_FRAMES_IN_USE,   16'h8000, 1, '{1'b0, 6'd1, 16'd2, 1'b0}},
      '{1, CSR_FRAMES_IN_USE,   16'd3,    0, '0},
      '{0, CSR_FRAMES_IN_USE,   16'h0001, 0, '0},
      '{0, CSR_FRAMES_IN_USE,   16'h0002, 0, '0},
      '{0, CSR_FRAMES_IN_USE,   16'h0003, 0, '0},
      '{0, CSR_FRAMES_IN_USE,   16'h0001, 0, '0},
      '{0, CSR_FRAMES_IN_USE,   16'h0002, 0, '0},
      '{0, CSR_FRAMES_IN_USE,   16'h0004, 0, '0},
      '{0, CSR_FRAMES_IN_USE,   16'h0003, 0, '0},
      '{0, CSR_FRAMES_IN_USE,   16'h0004, 0, '0}
   };

   int phase_frames [PHASES] = '{1, 64, 3, 127, 8, 0, 63};
   int phase_ilen   [PHASES] = '{1, 1000, 7, 65535, 0, 13, 250};

   initial begin
      logic [PAGE_W-1:0] pool_base;
      logic [PAGE_W-1:0] page;
      int                span;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_FRAMES_IN_USE;
      csr_wdata  <= '0;
      send_idle = 14;
      recv_idle = 79;
      frames_reg   = FIU_RESET;
      ilen_reg     = ILEN_RESET;
      faults_now   = '0;
      position_now = '0;
      flush_table();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].is_csr) csr_write(script[i].idx, script[i].value);
         else send_page(script[i].value, script[i].typed, script[i].want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 3) begin
            send_idle = 79;
            recv_idle = 14;
         end else if (ph == 5) begin
            send_idle = 0;
            recv_idle = 0;
         end
         // junk in the upper data bits is masked off by the block
         csr_write(CSR_FRAMES_IN_USE,
                   16'(phase_frames[ph]) | (16'($urandom_range(511)) << FIU_W));
         csr_write(CSR_INTERVAL_LENGTH, 16'(phase_ilen[ph]));
         pool_base = 16'($urandom);
         span = frames_live() + frames_live() / 2 + 1;
         for (int k = 0; k < PHASE_REQS; k++) begin
            if ($urandom_range(99) < 20) page = 16'($urandom);
            else page = pool_base + 16'($urandom_range(span));
            send_page(page, 0, '0);
            if (ph == 2 && k == PHASE_REQS / 2) drain_lookups();
         end
      end

      drain_lookups();
      repeat (15) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
